[hdl/pdll_pkg.sv]
// ----------------------------------------------------------------------------
// pdll_pkg
// Field widths, operation and status codes of the positional linked list.
// ----------------------------------------------------------------------------
package pdll_pkg;

    localparam int POS_W     = 7;
    localparam int ELEM_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    localparam logic [ELEM_W-1:0] ELEM_NONE = 8'h00;
    localparam logic [ELEM_W-1:0] ELEM_FAIL = 8'hFF;

endpackage

[hdl/pdll_ram.sv]
// ----------------------------------------------------------------------------
// pdll_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/positional_doubly_linked_list_unit.sv]
// ----------------------------------------------------------------------------
// positional_doubly_linked_list_unit
// Bounded ordered list of bytes in a linked node store with a free stack.
// Accepts one word at a time and returns one result word for each; the link
// walk reads one forward link per cycle from the node RAM. Errors skip the
// walk and are reported from the done state. After reset a sweep over every
// node chains the free stack; s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module positional_doubly_linked_list_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pdll_pkg::S_TDATA_W-1:0] s_tdata,  // position[6:0], elem_in[14:7]
    input  logic [0:0]                     s_tuser,  // func[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pdll_pkg::M_TDATA_W-1:0] m_tdata   // elem_out[7:0], status[9:8], count[16:10]
);

    import pdll_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (LW + 1 > POS_W + 1) ? LW + 1 : POS_W + 1;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FETCH,
        ST_UPD1,
        ST_UPD2,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       clr_idx_reg;
    logic [LW-1:0]       front_reg;
    logic [LW-1:0]       back_reg;
    logic [LW-1:0]       free_top_reg;
    logic [LW-1:0]       free_next_reg;
    logic [LW-1:0]       count_reg;
    logic [LW-1:0]       cur_reg;
    logic [LW-1:0]       prev_reg;
    logic                pend_reg;
    logic [POS_W-1:0]    rem_reg;
    logic                func_reg;
    logic [ELEM_W-1:0]   elem_reg;
    logic [ELEM_W-1:0]   res_elem_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              in_func;
    logic [POS_W-1:0]  in_pos;
    logic [ELEM_W-1:0] in_elem;
    logic [CMPW-1:0]   pos_ext;
    logic [CMPW-1:0]   count_ext;
    logic              ins_bad;
    logic              del_bad;
    logic              is_full;

    logic [LW-1:0]     cur_now;
    logic [AW-1:0]     rd_addr;

    logic              val_we;
    logic [AW-1:0]     val_waddr;
    logic [ELEM_W-1:0] val_rdata;
    logic              fwd_we;
    logic [AW-1:0]     fwd_waddr;
    logic [LW-1:0]     fwd_wdata;
    logic [LW-1:0]     fwd_rdata;
    logic              bck_we;
    logic [AW-1:0]     bck_waddr;
    logic [LW-1:0]     bck_wdata;
    logic [LW-1:0]     bck_rdata;

    assign in_func   = s_tuser[0];
    assign in_pos    = s_tdata[POS_W-1:0];
    assign in_elem   = s_tdata[POS_W+ELEM_W-1:POS_W];
    assign pos_ext   = CMPW'(in_pos);
    assign count_ext = CMPW'(count_reg);
    assign ins_bad   = (in_pos == '0) || (pos_ext > count_ext + CMPW'(1));
    assign del_bad   = (in_pos == '0) || (pos_ext > count_ext);
    assign is_full   = (count_ext >= CMPW'(CAPACITY)) || (free_top_reg == NIL);

    assign cur_now = pend_reg ? fwd_rdata : cur_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        rd_addr   = AW'(cur_reg);
        val_we    = 1'b0;
        val_waddr = AW'(free_top_reg);
        fwd_we    = 1'b0;
        fwd_waddr = AW'(cur_reg);
        fwd_wdata = cur_reg;
        bck_we    = 1'b0;
        bck_waddr = AW'(cur_reg);
        bck_wdata = prev_reg;
        case (state_reg)
            ST_CLEAR: begin
                fwd_we    = 1'b1;
                fwd_waddr = clr_idx_reg;
                fwd_wdata = LW'(clr_idx_reg) + LW'(1);
            end
            ST_WALK: begin
                rd_addr = AW'(cur_now);
            end
            ST_FETCH: begin
                rd_addr = (func_reg == FUNC_INSERT) ? AW'(free_top_reg) : AW'(cur_reg);
            end
            ST_UPD1: begin
                fwd_we = 1'b1;
                bck_we = 1'b1;
                if (func_reg == FUNC_INSERT) begin
                    val_we    = 1'b1;
                    fwd_waddr = AW'(free_top_reg);
                    fwd_wdata = cur_reg;
                    bck_waddr = AW'(free_top_reg);
                    bck_wdata = prev_reg;
                end else begin
                    fwd_waddr = AW'(cur_reg);
                    fwd_wdata = free_top_reg;
                    bck_waddr = AW'(cur_reg);
                    bck_wdata = NIL;
                end
            end
            ST_UPD2: begin
                fwd_we    = (prev_reg != NIL);
                fwd_waddr = AW'(prev_reg);
                fwd_wdata = (func_reg == FUNC_INSERT) ? free_top_reg : cur_reg;
                bck_we    = (cur_reg != NIL);
                bck_waddr = AW'(cur_reg);
                bck_wdata = (func_reg == FUNC_INSERT) ? free_top_reg : prev_reg;
            end
            default: begin
            end
        endcase
    end

    pdll_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_value_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (elem_reg),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    pdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_fwd_ram (
        .aclk  (aclk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (rd_addr),
        .rdata (fwd_rdata)
    );

    pdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_back_ram (
        .aclk  (aclk),
        .we    (bck_we),
        .waddr (bck_waddr),
        .wdata (bck_wdata),
        .raddr (rd_addr),
        .rdata (bck_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            front_reg    <= NIL;
            back_reg     <= NIL;
            free_top_reg <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + AW'(1);
                    if (clr_idx_reg == AW'(CAPACITY - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg <= in_func;
                        elem_reg <= in_elem;
                        cur_reg  <= front_reg;
                        prev_reg <= NIL;
                        pend_reg <= 1'b0;
                        rem_reg  <= in_pos - POS_W'(1);
                        if ((in_func == FUNC_INSERT) && ins_bad) begin
                            res_status_reg <= STATUS_BAD_POS;
                            res_elem_reg   <= ELEM_NONE;
                            state_reg      <= ST_DONE;
                        end else if ((in_func == FUNC_INSERT) && is_full) begin
                            res_status_reg <= STATUS_FULL;
                            res_elem_reg   <= ELEM_NONE;
                            state_reg      <= ST_DONE;
                        end else if ((in_func == FUNC_DELETE) && del_bad) begin
                            res_status_reg <= STATUS_BAD_POS;
                            res_elem_reg   <= ELEM_FAIL;
                            state_reg      <= ST_DONE;
                        end else begin
                            res_status_reg <= STATUS_OK;
                            res_elem_reg   <= ELEM_NONE;
                            state_reg      <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (rem_reg == '0) begin
                        cur_reg   <= cur_now;
                        pend_reg  <= 1'b0;
                        state_reg <= ST_FETCH;
                    end else begin
                        prev_reg <= cur_now;
                        pend_reg <= 1'b1;
                        rem_reg  <= rem_reg - POS_W'(1);
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_UPD1;
                end
                ST_UPD1: begin
                    if (func_reg == FUNC_INSERT) begin
                        free_next_reg <= fwd_rdata;
                    end else begin
                        free_top_reg <= cur_reg;
                        cur_reg      <= fwd_rdata;
                        prev_reg     <= bck_rdata;
                        res_elem_reg <= val_rdata;
                    end
                    state_reg <= ST_UPD2;
                end
                ST_UPD2: begin
                    if (func_reg == FUNC_INSERT) begin
                        if (prev_reg == NIL) begin
                            front_reg <= free_top_reg;
                        end
                        if (cur_reg == NIL) begin
                            back_reg <= free_top_reg;
                        end
                        free_top_reg <= free_next_reg;
                        count_reg    <= count_reg + LW'(1);
                    end else begin
                        if (prev_reg == NIL) begin
                            front_reg <= cur_reg;
                        end
                        if (cur_reg == NIL) begin
                            back_reg <= prev_reg;
                        end
                        count_reg <= count_reg - LW'(1);
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_TDATA_W'({COUNT_W'(count_reg), res_status_reg,
                                                    res_elem_reg});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/sv/pdll_list_checker.sv]
// ----------------------------------------------------------------------------
// pdll_list_checker
// Watches both streams of the positional linked list, keeps its own copy of
// the node store, links and free stack, works out the result word for every
// accepted input word and compares each result word field by field in order.
// ----------------------------------------------------------------------------
module pdll_list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pdll_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pdll_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fails,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pdll_pkg::*;

    localparam logic [POS_W-1:0] NIL = POS_W'(CAPACITY);

    typedef struct packed {
        logic [ELEM_W-1:0]   elem;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    logic [ELEM_W-1:0] node_val  [CAPACITY];
    logic [POS_W-1:0]  next_node [CAPACITY];
    logic [POS_W-1:0]  prev_node [CAPACITY];
    logic [POS_W-1:0]  head;
    logic [POS_W-1:0]  tail;
    logic [POS_W-1:0]  free_head;
    int                length;
    list_result_t      awaited_results[$];

    initial begin
        fails   = 0;
        pending = 0;
    end

    function automatic void list_clear();
        for (int i = 0; i < CAPACITY; i++) begin
            node_val[i]  = '0;
            next_node[i] = POS_W'(i + 1);
            prev_node[i] = NIL;
        end
        head      = NIL;
        tail      = NIL;
        free_head = '0;
        length    = 0;
    endfunction

    function automatic logic [POS_W-1:0] node_at(int k);
        logic [POS_W-1:0] n;
        n = head;
        for (int i = 1; i < k && n != NIL; i++)
            n = next_node[n];
        return n;
    endfunction

    function automatic list_result_t list_apply(logic f, int pos, logic [ELEM_W-1:0] e);
        list_result_t     r;
        logic [POS_W-1:0] node;
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] right;
        r.elem   = ELEM_NONE;
        r.status = STATUS_OK;
        if (f == FUNC_INSERT) begin
            if (pos < 1 || pos > length + 1) begin
                r.status = STATUS_BAD_POS;
            end else if (length >= CAPACITY || free_head == NIL) begin
                r.status = STATUS_FULL;
            end else begin
                node      = free_head;
                left      = (pos == 1) ? NIL : node_at(pos - 1);
                right     = (left != NIL) ? next_node[left] : head;
                free_head = next_node[node];
                node_val[node]  = e;
                next_node[node] = right;
                prev_node[node] = left;
                if (left != NIL) next_node[left] = node;
                else head = node;
                if (right != NIL) prev_node[right] = node;
                else tail = node;
                length++;
            end
        end else begin
            if (pos < 1 || pos > length) begin
                r.status = STATUS_BAD_POS;
                r.elem   = ELEM_FAIL;
            end else begin
                node   = node_at(pos);
                left   = prev_node[node];
                right  = next_node[node];
                r.elem = node_val[node];
                if (left != NIL) next_node[left] = right;
                else head = right;
                if (right != NIL) prev_node[right] = left;
                else tail = left;
                next_node[node] = free_head;
                prev_node[node] = NIL;
                free_head       = node;
                length--;
            end
        end
        r.count = COUNT_W'(length);
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            list_clear();
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.elem   = m_tdata[ELEM_W-1:0];
                got.status = m_tdata[ELEM_W +: STATUS_W];
                got.count  = m_tdata[ELEM_W+STATUS_W +: COUNT_W];
                if (awaited_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("elem_out", int'(want.elem), int'(got.elem));
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("count", int'(want.count), int'(got.count));
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(list_apply(s_tuser[0],
                                                     int'(s_tdata[POS_W-1:0]),
                                                     s_tdata[POS_W +: ELEM_W]));
        end
        pending <= awaited_results.size();
    end

endmodule

[tb/sv/tb_positional_doubly_linked_list_unit.sv]
// ----------------------------------------------------------------------------
// tb_positional_doubly_linked_list_unit
// Drives insert and delete words into the positional linked list: a directed
// pass over empty, edge and bad positions, then random bursts that fill the
// store to overflow, drain it past empty, mix operations and send noise.
// Both sides stall at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_positional_doubly_linked_list_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import pdll_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_WORDS = 400;
    localparam int IDLE_PCT     = 30;
    localparam int WATCHDOG     = 5000;
    localparam int DRAIN_CYCLES = 150;

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_NOISE} burst_kind_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fails;
    int                   pending;
    int                   list_len    = 0;
    int                   words_sent  = 0;
    int                   quiet_count = 0;
    logic                 no_idle     = 1'b0;

    always #5 aclk = ~aclk;

    positional_doubly_linked_list_unit #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pdll_list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .fails    (fails),
        .pending  (pending)
    );

    always @(posedge aclk)
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG) begin
            $display("tb_positional_doubly_linked_list_unit: FAIL");
            $finish;
        end
    end

    task automatic push_word(input logic f, input int pos, input int e);
        no_idle = (words_sent >= 150 && words_sent < 230);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {1'b0, ELEM_W'(e), POS_W'(pos)};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (f == FUNC_INSERT) begin
            if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) list_len++;
        end else if (pos >= 1 && pos <= list_len) begin
            list_len--;
        end
    endtask

    task automatic run_burst(input burst_kind_t kind);
        case (kind)
            BURST_FILL: begin
                while (list_len < CAPACITY)
                    push_word(FUNC_INSERT, $urandom_range(1, list_len + 1), $urandom_range(255));
                push_word(FUNC_INSERT, $urandom_range(1, list_len + 1), $urandom_range(255));
                push_word(FUNC_INSERT, $urandom_range(list_len + 2, 127), $urandom_range(255));
                push_word(FUNC_INSERT, 0, $urandom_range(255));
            end
            BURST_DRAIN: begin
                while (list_len > 0)
                    push_word(FUNC_DELETE, $urandom_range(1, list_len), $urandom_range(255));
                push_word(FUNC_DELETE, 1, $urandom_range(255));
                push_word(FUNC_DELETE, $urandom_range(127), $urandom_range(255));
            end
            BURST_MIXED: begin
                repeat (20) begin
                    if (list_len == 0 || (list_len < CAPACITY && $urandom_range(1)))
                        push_word(FUNC_INSERT, $urandom_range(1, list_len + 1),
                                  $urandom_range(255));
                    else
                        push_word(FUNC_DELETE, $urandom_range(1, list_len),
                                  $urandom_range(255));
                end
            end
            default: begin
                repeat (8)
                    push_word(1'($urandom_range(1)), $urandom_range(127), $urandom_range(255));
            end
        endcase
    endtask

    initial begin
        int start_count;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        push_word(FUNC_DELETE, 1, 'h3C);
        push_word(FUNC_DELETE, 0, 'h00);
        push_word(FUNC_INSERT, 0, 'h11);
        push_word(FUNC_INSERT, 2, 'h22);
        push_word(FUNC_INSERT, 1, 'hFF);
        push_word(FUNC_INSERT, 1, 'h00);
        push_word(FUNC_INSERT, 3, 'hA5);
        push_word(FUNC_INSERT, 2, 'h5A);
        push_word(FUNC_INSERT, 127, 'h80);
        push_word(FUNC_INSERT, 6, 'h01);
        push_word(FUNC_DELETE, 127, 'hFF);
        push_word(FUNC_DELETE, 5, 'h00);
        push_word(FUNC_DELETE, 2, 'h00);
        push_word(FUNC_DELETE, 3, 'h00);
        push_word(FUNC_INSERT, 3, 'h7E);
        push_word(FUNC_DELETE, 1, 'h00);
        push_word(FUNC_DELETE, 2, 'h00);
        push_word(FUNC_DELETE, 1, 'h00);
        push_word(FUNC_DELETE, 1, 'h00);
        push_word(FUNC_INSERT, 1, 'hC3);

        start_count = words_sent;
        run_burst(BURST_FILL);
        while (words_sent - start_count < RANDOM_WORDS) begin
            case ($urandom_range(9))
                0, 1, 2: run_burst(BURST_FILL);
                3, 4, 5: run_burst(BURST_DRAIN);
                6, 7, 8: run_burst(BURST_MIXED);
                default: run_burst(BURST_NOISE);
            endcase
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0)
            $display("tb_positional_doubly_linked_list_unit: PASS");
        else
            $display("tb_positional_doubly_linked_list_unit: FAIL");
        $finish;
    end

endmodule
